// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the chunked body decoder modules.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cbd_pkg.sv =====
// Shared types, constants and helpers for the chunked body decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cbd_pkg;

  localparam logic [7:0]  CHAR_CR       = 8'h0D;
  localparam logic [7:0]  CHAR_LF       = 8'h0A;
  localparam logic [7:0]  CHAR_SEMI     = 8'h3B;
  localparam logic [31:0] MAX_BODY_RST  = 32'd1048576;

  typedef enum logic [2:0] {
    KIND_FRAME  = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_BAD    = 3'd3,
    KIND_TOOBIG = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [31:0] length;
  } cbd_result_t;

  // Returns {is_hex, value} for an ASCII byte.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hdl/chunked_body_decoder.sv =====
// Top level of the chunked transfer body decoder.
// Depends on cbd_pkg, cbd_parser, cbd_out_reg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// Usage: raw bytes of a chunked body enter on the input channel (in_valid_i,
// in_stall_o, in_byte_i); each byte yields exactly one result word on the
// output channel (out_valid_o, out_stall_i, kind_o, body_byte_o,
// body_length_o). kind_o tells framing, body byte, completion (with the body
// length), malformed or too large; after completion or an error the decoder
// expects a new body.
// A byte is captured in an input register, decoded by the framing state
// machine and its result is written to the output register, where it is
// held until the receiver takes it.
// One byte is accepted every cycle while the receiver does not stall; the rate
// is set by the framing state, which is updated once for each byte it sees.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o is raised until the result is taken.
// Reset clears the pipeline and framing state and sets the body limit to
// 1048576 bytes. The limit register is written through max_body_bytes_we_i;
// the user is bound to write it only while the decoder is idle; the block has no check.

module chunked_body_decoder import cbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        max_body_bytes_we_i,
  input  logic [31:0] max_body_bytes_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  body_byte_o,
  output logic [31:0] body_length_o
);

  logic        advance;
  logic        fire;
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic [31:0] max_q;
  logic        out_vld;
  cbd_result_t res;
  cbd_result_t out_res;

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance    = !(out_vld && out_stall_i);
  assign in_stall_o = !advance;
  assign fire       = advance && in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      max_q    <= MAX_BODY_RST;
    end else begin
      if (advance) in_vld_q <= in_valid_i;
      if (max_body_bytes_we_i) max_q <= max_body_bytes_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  cbd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .max_body_i (max_q),
    .res_o      (res)
  );

  cbd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .fire_i    (fire),
    .res_i     (res),
    .valid_o   (out_vld),
    .res_o     (out_res)
  );

  assign out_valid_o   = out_vld;
  assign kind_o        = out_res.kind;
  assign body_byte_o   = out_res.data;
  assign body_length_o = out_res.length;

  `CBD_ASSERT_IMP(a_stall_needs_result, in_stall_o, out_vld,
                  "input stalled while no result is waiting")

endmodule

// ===== hdl/cbd_parser.sv =====
// Chunk framing state machine: decodes one word per enabled cycle.
// Depends on cbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbd_parser import cbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] max_body_i,
  output cbd_result_t res_o
);

  typedef enum logic [2:0] {
    PH_SIZE, PH_EXT, PH_DATA, PH_DATAEND, PH_TRAILER
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [63:0] acc_q, acc_d;
  logic        seen_q, seen_d;
  logic        cr_q, cr_d;
  logic [31:0] left_q, left_d;
  logic [31:0] total_q, total_d;

  logic [4:0]  hex;
  logic [31:0] room;
  logic        too_big;
  logic [31:0] left_dec;
  cbd_result_t res;

  assign hex  = hex_decode(byte_i);
  assign room = max_body_i - total_q;
  // A nonzero size is refused if it cannot fit in the room left under the limit.
  assign too_big = (acc_q != 64'd0) &&
                   ((total_q > max_body_i) || (acc_q[63:32] != 32'd0) ||
                    (acc_q[31:0] > room));
  assign left_dec = (left_q != 32'd0) ? left_q - 32'd1 : 32'd0;

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    cr_d       = cr_q;
    left_d     = left_q;
    total_d    = total_q;
    res.kind   = KIND_FRAME;
    res.data   = 8'd0;
    res.length = 32'd0;

    unique case (phase_q)
      PH_SIZE: begin
        if (cr_q) begin
          if (byte_i != CHAR_LF || !seen_q) begin
            res.kind = KIND_BAD;
          end else if (too_big) begin
            res.kind = KIND_TOOBIG;
          end else begin
            cr_d = 1'b0;
            if (acc_q == 64'd0) begin
              phase_d = PH_TRAILER;
            end else begin
              left_d  = acc_q[31:0];
              phase_d = PH_DATA;
            end
          end
        end else if (byte_i == CHAR_CR) begin
          cr_d = 1'b1;
        end else if (byte_i == CHAR_SEMI) begin
          if (!seen_q) begin
            res.kind = KIND_BAD;
          end else if (too_big) begin
            res.kind = KIND_TOOBIG;
          end else begin
            phase_d = PH_EXT;
          end
        end else if (!hex[4] || acc_q[63:60] != 4'd0) begin
          // Not a hex digit, or the next digit would carry past 64 bits.
          res.kind = KIND_BAD;
        end else begin
          acc_d  = {acc_q[59:0], hex[3:0]};
          seen_d = 1'b1;
        end
      end
      PH_EXT, PH_TRAILER: begin
        if (byte_i == CHAR_LF && cr_q) begin
          if (phase_q == PH_EXT) begin
            cr_d = 1'b0;
            if (acc_q == 64'd0) begin
              phase_d = PH_TRAILER;
            end else begin
              left_d  = acc_q[31:0];
              phase_d = PH_DATA;
            end
          end else begin
            res.kind   = KIND_DONE;
            res.length = total_q;
          end
        end else begin
          cr_d = (byte_i == CHAR_CR);
        end
      end
      PH_DATA: begin
        res.kind = KIND_BYTE;
        res.data = byte_i;
        total_d  = total_q + 32'd1;
        left_d   = left_dec;
        if (left_dec == 32'd0) begin
          phase_d = PH_DATAEND;
          cr_d    = 1'b0;
        end
      end
      PH_DATAEND: begin
        if (!cr_q) begin
          if (byte_i == CHAR_CR) cr_d = 1'b1;
          else res.kind = KIND_BAD;
        end else if (byte_i == CHAR_LF) begin
          phase_d = PH_SIZE;
          acc_d   = 64'd0;
          seen_d  = 1'b0;
          cr_d    = 1'b0;
        end else begin
          res.kind = KIND_BAD;
        end
      end
      default: begin
        phase_d = PH_SIZE;
      end
    endcase

    // Completion and every error start a fresh body.
    if (res.kind inside {KIND_DONE, KIND_BAD, KIND_TOOBIG}) begin
      phase_d = PH_SIZE;
      acc_d   = 64'd0;
      seen_d  = 1'b0;
      cr_d    = 1'b0;
      left_d  = 32'd0;
      total_d = 32'd0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      acc_q   <= 64'd0;
      seen_q  <= 1'b0;
      cr_q    <= 1'b0;
      left_q  <= 32'd0;
      total_q <= 32'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      cr_q    <= cr_d;
      left_q  <= left_d;
      total_q <= total_d;
    end
  end

  `CBD_ASSERT_IMP(a_data_is_byte, fire_i && phase_q == PH_DATA, res.kind == KIND_BYTE,
                  "data phase produced a non-body result")
  `CBD_ASSERT_NXT(a_bad_restarts, fire_i && res.kind == KIND_BAD,
                  phase_q == PH_SIZE && acc_q == 64'd0 && total_q == 32'd0,
                  "malformed word did not restart the body")

endmodule

// ===== hdl/cbd_out_reg.sv =====
// Result register: holds one decoded result until the receiver takes it.
// Depends on cbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbd_out_reg import cbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic        fire_i,
  input  cbd_result_t res_i,
  output logic        valid_o,
  output cbd_result_t res_o
);

  logic        valid_q;
  cbd_result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && fire_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `CBD_ASSERT_IMP(a_len_only_done, valid_q && res_q.kind != KIND_DONE,
                  res_q.length == 32'd0, "length shown on a result that is not completion")

endmodule

// ===== sim/chunked_body_decoder_tb.sv =====
// Self-checking testbench for chunked_body_decoder: drives chunked bodies byte by byte and
// compares every result word against a cycle-free predictor of the chunk framing.
// Depends on cbd_pkg and the chunked_body_decoder RTL only.
`timescale 1ns / 1ps

module chunked_body_decoder_tb;
  import cbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 8;

  typedef enum logic [2:0] {
    AT_SIZE,
    AT_EXT,
    AT_DATA,
    AT_DATA_END,
    AT_TRAILER
  } frame_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        max_body_bytes_we_i = 1'b0;
  logic [31:0] max_body_bytes_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  body_byte_o;
  logic [31:0] body_length_o;

  chunked_body_decoder dut (.*);

  // Predictor state: the framing of the stream as seen by the decoder.
  frame_phase_e dec_phase  = AT_SIZE;
  logic [63:0]  size_acc   = '0;
  logic         got_digit  = 1'b0;
  logic         saw_cr     = 1'b0;
  logic [31:0]  chunk_left = '0;
  logic [31:0]  body_sum   = '0;
  logic [31:0]  limit_reg  = MAX_BODY_RST;

  logic [7:0]  raw_bytes[$];
  logic [7:0]  body_text[$];
  cbd_result_t decoded_words[$];
  cbd_result_t next_word;

  int mismatch_count = 0;
  int send_gap = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit long_hold_done = 1'b0;
  bit quiet = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic bit chunk_exceeds_limit();
    if (size_acc == 64'd0) return 1'b0;
    if (body_sum > limit_reg) return 1'b1;
    return size_acc > {32'd0, limit_reg - body_sum};
  endfunction

  function automatic void finish_size_line();
    saw_cr = 1'b0;
    if (size_acc == 64'd0) begin
      dec_phase = AT_TRAILER;
    end else begin
      chunk_left = size_acc[31:0];
      dec_phase = AT_DATA;
    end
  endfunction

  // Works out the one result word that a byte causes and queues it.
  function automatic void decode_byte(input logic [7:0] c);
    cbd_result_t w;
    logic [3:0]  nib;
    logic        is_hex;
    w.kind = KIND_FRAME;
    w.data = '0;
    w.length = '0;
    is_hex = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
    else begin
      nib = '0;
      is_hex = 1'b0;
    end
    case (dec_phase)
      AT_SIZE: begin
        if (saw_cr) begin
          if (c != CHAR_LF || !got_digit) w.kind = KIND_BAD;
          else if (chunk_exceeds_limit()) w.kind = KIND_TOOBIG;
          else finish_size_line();
        end else if (c == CHAR_CR) begin
          saw_cr = 1'b1;
        end else if (c == CHAR_SEMI) begin
          if (!got_digit) w.kind = KIND_BAD;
          else if (chunk_exceeds_limit()) w.kind = KIND_TOOBIG;
          else dec_phase = AT_EXT;
        end else if (!is_hex || size_acc[63:60] != 4'd0) begin
          // A set top nibble means one more digit would carry past 64 bits.
          w.kind = KIND_BAD;
        end else begin
          size_acc = {size_acc[59:0], nib};
          got_digit = 1'b1;
        end
      end
      AT_EXT, AT_TRAILER: begin
        if (c == CHAR_LF && saw_cr) begin
          if (dec_phase == AT_EXT) begin
            finish_size_line();
          end else begin
            w.kind = KIND_DONE;
            w.length = body_sum;
          end
        end else begin
          saw_cr = (c == CHAR_CR);
        end
      end
      AT_DATA: begin
        w.kind = KIND_BYTE;
        w.data = c;
        body_sum = body_sum + 32'd1;
        if (chunk_left > 0) chunk_left = chunk_left - 32'd1;
        if (chunk_left == 0) begin
          dec_phase = AT_DATA_END;
          saw_cr = 1'b0;
        end
      end
      default: begin
        if (!saw_cr) begin
          if (c == CHAR_CR) saw_cr = 1'b1;
          else w.kind = KIND_BAD;
        end else if (c == CHAR_LF) begin
          dec_phase = AT_SIZE;
          size_acc = '0;
          got_digit = 1'b0;
          saw_cr = 1'b0;
        end else begin
          w.kind = KIND_BAD;
        end
      end
    endcase
    // Completion and every error start a new body; the limit is kept.
    if (w.kind == KIND_DONE || w.kind == KIND_BAD || w.kind == KIND_TOOBIG) begin
      dec_phase = AT_SIZE;
      size_acc = '0;
      got_digit = 1'b0;
      saw_cr = 1'b0;
      chunk_left = '0;
      body_sum = '0;
    end
    decoded_words.push_back(w);
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(v - 10);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_text.push_back(s[i]);
  endfunction

  function automatic void push_size(input int v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(hex_char(v % 16));
      v = v / 16;
    end while (v != 0);
    if ($urandom_range(0, 7) == 0) digits.push_front(8'h30);
    foreach (digits[i]) body_text.push_back(digits[i]);
  endfunction

  // Optional extension of arbitrary bytes, with stray CRs but never a CRLF pair.
  function automatic void push_ext();
    logic [7:0] b;
    logic [7:0] prev;
    if ($urandom_range(0, 3) != 0) return;
    body_text.push_back(CHAR_SEMI);
    prev = 8'h00;
    repeat ($urandom_range(0, 6)) begin
      b = 8'($urandom);
      if ($urandom_range(0, 5) == 0) b = CHAR_CR;
      if (b == CHAR_LF && prev == CHAR_CR) b = 8'h3D;
      body_text.push_back(b);
      prev = b;
    end
  endfunction

  function automatic void build_body(input int max_chunk);
    int len;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 9) == 0) begin
        // At least nine digits: beyond any limit, and past 64 bits when seventeen.
        body_text.push_back(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(8, 16)) body_text.push_back(hex_char($urandom_range(0, 15)));
        push_text("\015\012");
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_chunk)
                                          : $urandom_range(1, 6);
        push_size(len);
        push_ext();
        push_text("\015\012");
        repeat (len) body_text.push_back(8'($urandom));
        push_text("\015\012");
      end
    end
    push_size(0);
    push_ext();
    push_text("\015\012");
    if ($urandom_range(0, 3) == 0) begin
      push_text("X-Sum: ");
      repeat ($urandom_range(1, 4)) body_text.push_back(hex_char($urandom_range(0, 15)));
      push_text("\015\012");
    end
    push_text("\015\012");
  endfunction

  function automatic void commit_text();
    while (body_text.size() != 0) raw_bytes.push_back(body_text.pop_front());
  endfunction

  // Returns once every queued byte has gone in and every result word has come out.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (raw_bytes.size() != 0 || in_valid_i || decoded_words.size() != 0);
  endtask

  task automatic write_limit(input logic [31:0] v);
    max_body_bytes_we_i <= 1'b1;
    max_body_bytes_i <= v;
    limit_reg = v;
    @(posedge clk_i);
    max_body_bytes_we_i <= 1'b0;
  endtask

  task automatic run_random_phase(input int budget, input int max_chunk);
    int queued;
    int pos;
    queued = 0;
    while (queued < budget) begin
      build_body(max_chunk);
      if ($urandom_range(0, 7) == 0) begin
        pos = $urandom_range(0, body_text.size() - 1);
        case ($urandom_range(0, 2))
          0: body_text[pos] = 8'($urandom);
          1: while (body_text.size() > pos + 1) void'(body_text.pop_back());
          default: body_text.insert(pos, 8'($urandom));
        endcase
      end
      if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(1, 8)) body_text.push_back(8'($urandom));
      end
      queued += body_text.size();
      commit_text();
    end
    wait_idle();
  endtask

  // Sender: offers queued bytes, predicting each one as it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) decode_byte(in_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (raw_bytes.size() != 0) begin
          in_valid_i <= 1'b1;
          in_byte_i <= raw_bytes.pop_front();
          if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted word and stalls in bursts, once for a long while.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_words.size() == 0) begin
          report_mismatch("result word with none expected", 32'(kind_o), 32'd0);
        end else begin
          next_word = decoded_words.pop_front();
          if (kind_o !== next_word.kind) report_mismatch("kind", 32'(kind_o), 32'(next_word.kind));
          if (body_byte_o !== next_word.data) begin
            report_mismatch("body byte", 32'(body_byte_o), 32'(next_word.data));
          end
          if (body_length_o !== next_word.length) begin
            report_mismatch("body length", body_length_o, next_word.length);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && raw_bytes.size() > 100) begin
        // Long hold while the sender keeps offering, so the input side backs up.
        long_hold_done <= 1'b1;
        hold_left <= 150;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_left <= $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || max_body_bytes_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] extreme_data[10];
    extreme_data = '{8'h00, 8'hFF, 8'h0D, 8'h0A, 8'h55, 8'hAA, 8'h3B, 8'h30, 8'h7F, 8'h80};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset limit; \015\012 is CRLF throughout.
    push_text("0a;name=v\015\012");
    foreach (extreme_data[i]) body_text.push_back(extreme_data[i]);
    push_text("\015\012");
    push_text("0\015\012");
    push_text("T: v\015\012");
    push_text(";");
    push_text("\015\012");
    push_text("1\015X");
    push_text("g");
    push_text("11111111111111111");
    push_text("FFFFF1\015\012");
    push_text("2;\015x\015\012ab\015\012");
    push_text("0\015\012\015\012");
    push_text("1\015\012Z\015Y");
    push_text("1\015\012ZQ");
    commit_text();
    wait_idle();

    // Bring the framing to the start of a body, then build up a running total.
    while (dec_phase != AT_SIZE || got_digit || saw_cr) begin
      case (dec_phase)
        AT_DATA: repeat ((chunk_left > 0) ? chunk_left : 32'd1) raw_bytes.push_back(8'h64);
        AT_EXT, AT_TRAILER: raw_bytes.push_back(saw_cr ? CHAR_LF : CHAR_CR);
        default: raw_bytes.push_back(8'h47);
      endcase
      wait_idle();
    end
    push_text("20\015\012");
    repeat (32) body_text.push_back(8'($urandom));
    push_text("\015\012");
    commit_text();
    wait_idle();

    // The limit now sits below the total already passed out.
    write_limit(32'd16);
    push_text("5\015\012");
    push_text("3\015\012xyz\015\012");
    push_text("0\015\012\015\012");
    commit_text();
    wait_idle();

    write_limit(32'd0);
    push_text("0\015\012\015\012");
    push_text("1;");
    commit_text();
    wait_idle();

    write_limit(32'hFFFF_FFFF);
    push_text("100000000\015\012");
    push_text("4\015\012wxyz\015\012");
    push_text("0\015\012\015\012");
    commit_text();
    wait_idle();

    run_random_phase(400, 40);
    write_limit(32'd0);
    run_random_phase(200, 8);
    write_limit($urandom_range(4, 64));
    run_random_phase(500, 24);
    write_limit($urandom);
    run_random_phase(400, 40);
    quiet = 1'b1;
    write_limit(MAX_BODY_RST);
    run_random_phase(400, 40);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && decoded_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
